// File: hw/rtl/tcoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcoc_pkg: shared types and constants
// Word layouts, telnet codes, parser states and emit job types for the codec.
// ----------------------------------------------------------------------------
package tcoc_pkg;

    localparam int SB_DEPTH_DEF = 40;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [7:0] K_IAC  = 8'hFF;
    localparam logic [7:0] K_DONT = 8'hFE;
    localparam logic [7:0] K_DO   = 8'hFD;
    localparam logic [7:0] K_WONT = 8'hFC;
    localparam logic [7:0] K_WILL = 8'hFB;
    localparam logic [7:0] K_SB   = 8'hFA;
    localparam logic [7:0] K_SE   = 8'hF0;
    localparam logic [7:0] K_CPO  = 8'h2C;
    localparam logic [7:0] K_SGA  = 8'h03;
    localparam logic [7:0] K_ECHO = 8'h01;
    localparam logic [7:0] K_BIN  = 8'h00;
    localparam logic [7:0] K_RESP = 8'd100;

    localparam logic [1:0] REQ_CLIENT = 2'd0;
    localparam logic [1:0] REQ_SERIAL = 2'd1;
    localparam logic [1:0] REQ_NEWCON = 2'd2;

    localparam logic [2:0] CFG_BAUD   = 3'd0;
    localparam logic [2:0] CFG_DBITS  = 3'd1;
    localparam logic [2:0] CFG_PARITY = 3'd2;
    localparam logic [2:0] CFG_STOP   = 3'd3;
    localparam logic [2:0] CFG_CTRL   = 3'd4;

    typedef enum logic [2:0] {
        PS_SNIFF, PS_RAW, PS_DATA, PS_IAC, PS_NEG, PS_SB, PS_SBIAC
    } parse_state_t;

    typedef enum logic [1:0] {
        JOB_NONE, JOB_BYTES, JOB_REPLY
    } job_kind_t;

    typedef enum logic [1:0] {
        BS_IDLE, BS_LOAD, BS_EMIT
    } back_state_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] byte_in;
    } in_word_t;

    typedef struct packed {
        logic        dest;
        logic [7:0]  byte_out;
        logic        last;
        logic [31:0] line_baud;
        logic [7:0]  line_data_bits;
        logic [2:0]  line_parity;
        logic [1:0]  line_stop;
        logic        telnet_active;
        logic        owns_line;
    } out_word_t;

    typedef struct packed {
        logic [31:0] baud;
        logic [7:0]  data_bits;
        logic [2:0]  parity;
        logic [1:0]  stop;
    } line_t;

    // One job for the back part: up to three plain bytes, or a subnegotiation
    // dispatch, and a set of flags that hold after the item.
    typedef struct packed {
        job_kind_t  kind;
        logic       dest;
        logic [1:0] nbytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       newcon;
        logic       take_own;
        logic       telnet;
        logic       owned;
        logic       bytes_after;
        logic [7:0] after_byte;
    } job_t;

endpackage

// File: hw/rtl/tcoc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcoc_ram: generic single-write memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: hw/rtl/tcoc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcoc_front: item parser
// Runs the telnet parser for one word a cycle while in_ok admits it, collects
// subnegotiation bytes into the store and hands jobs to the queue.
// ----------------------------------------------------------------------------
module tcoc_front #(
    parameter int SB_DEPTH = tcoc_pkg::SB_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_ok,
    input  tcoc_pkg::in_word_t          in_word,
    input  logic                        control_allowed,
    output tcoc_pkg::job_t              job,
    output logic                        job_valid,
    output logic                        sb_we,
    output logic [$clog2(SB_DEPTH)-1:0] sb_waddr,
    output logic [7:0]                  sb_wdata,
    output logic [$clog2(SB_DEPTH+1)-1:0] sb_count,
    output logic                        sb_hold
);

    localparam int CW = $clog2(SB_DEPTH + 1);

    tcoc_pkg::parse_state_t state_reg, state_next;
    logic                   telnet_reg, telnet_next;
    logic                   own_reg, own_next;
    logic [7:0]             pend_reg, pend_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   push;
    logic [7:0]             push_byte;
    logic [7:0]             b;
    logic                   is_neg;

    assign b = in_word.byte_in;
    assign is_neg = (b == tcoc_pkg::K_WILL) || (b == tcoc_pkg::K_WONT) ||
                    (b == tcoc_pkg::K_DO) || (b == tcoc_pkg::K_DONT);

    always_comb
    begin
        state_next = state_reg;
        telnet_next = telnet_reg;
        own_next = own_reg;
        pend_next = pend_reg;
        cnt_next = cnt_reg;
        push = 1'b0;
        push_byte = b;
        job = '0;
        job.kind = tcoc_pkg::JOB_NONE;
        job.dest = 1'b0;
        job.b0 = b;
        job.nbytes = 2'd1;
        case (in_word.req_type)
            tcoc_pkg::REQ_SERIAL:
            begin
                job.kind = tcoc_pkg::JOB_BYTES;
                job.dest = 1'b1;
                job.b1 = tcoc_pkg::K_IAC;
                job.nbytes = (telnet_reg && b == tcoc_pkg::K_IAC) ? 2'd2 : 2'd1;
            end
            tcoc_pkg::REQ_NEWCON:
            begin
                job.newcon = 1'b1;
                state_next = tcoc_pkg::PS_SNIFF;
                telnet_next = 1'b0;
                own_next = 1'b0;
                pend_next = '0;
            end
            tcoc_pkg::REQ_CLIENT:
            begin
                case (state_reg)
                    tcoc_pkg::PS_SNIFF:
                    begin
                        if (b != tcoc_pkg::K_IAC)
                        begin
                            state_next = tcoc_pkg::PS_RAW;
                            job.kind = tcoc_pkg::JOB_BYTES;
                        end
                        else
                        begin
                            telnet_next = 1'b1;
                            state_next = tcoc_pkg::PS_IAC;
                        end
                    end
                    tcoc_pkg::PS_RAW:
                    begin
                        job.kind = tcoc_pkg::JOB_BYTES;
                    end
                    tcoc_pkg::PS_DATA:
                    begin
                        if (b == tcoc_pkg::K_IAC)
                        begin
                            state_next = tcoc_pkg::PS_IAC;
                        end
                        else
                        begin
                            job.kind = tcoc_pkg::JOB_BYTES;
                        end
                    end
                    tcoc_pkg::PS_IAC:
                    begin
                        state_next = tcoc_pkg::PS_DATA;
                        if (b == tcoc_pkg::K_IAC)
                        begin
                            job.kind = tcoc_pkg::JOB_BYTES;
                        end
                        else if (b == tcoc_pkg::K_SB)
                        begin
                            cnt_next = '0;
                            state_next = tcoc_pkg::PS_SB;
                        end
                        else if (is_neg)
                        begin
                            pend_next = b;
                            state_next = tcoc_pkg::PS_NEG;
                        end
                    end
                    tcoc_pkg::PS_NEG:
                    begin
                        state_next = tcoc_pkg::PS_DATA;
                        job.dest = 1'b1;
                        job.b0 = tcoc_pkg::K_IAC;
                        job.b2 = b;
                        job.nbytes = 2'd3;
                        if (b == tcoc_pkg::K_CPO || b == tcoc_pkg::K_SGA ||
                            b == tcoc_pkg::K_BIN)
                        begin
                            if (pend_reg == tcoc_pkg::K_WILL)
                            begin
                                job.kind = tcoc_pkg::JOB_BYTES;
                                job.b1 = tcoc_pkg::K_DO;
                            end
                            else if (pend_reg == tcoc_pkg::K_DO)
                            begin
                                job.kind = tcoc_pkg::JOB_BYTES;
                                job.b1 = tcoc_pkg::K_WILL;
                            end
                        end
                        else if (b == tcoc_pkg::K_ECHO)
                        begin
                            if (pend_reg == tcoc_pkg::K_DO)
                            begin
                                job.kind = tcoc_pkg::JOB_BYTES;
                                job.b1 = tcoc_pkg::K_WONT;
                            end
                            else if (pend_reg == tcoc_pkg::K_WILL)
                            begin
                                job.kind = tcoc_pkg::JOB_BYTES;
                                job.b1 = tcoc_pkg::K_DONT;
                            end
                        end
                        else
                        begin
                            if (pend_reg == tcoc_pkg::K_WILL)
                            begin
                                job.kind = tcoc_pkg::JOB_BYTES;
                                job.b1 = tcoc_pkg::K_DONT;
                            end
                            else if (pend_reg == tcoc_pkg::K_DO)
                            begin
                                job.kind = tcoc_pkg::JOB_BYTES;
                                job.b1 = tcoc_pkg::K_WONT;
                            end
                        end
                        if (job.kind == tcoc_pkg::JOB_BYTES && b == tcoc_pkg::K_CPO &&
                            control_allowed)
                        begin
                            own_next = 1'b1;
                            job.take_own = 1'b1;
                        end
                    end
                    tcoc_pkg::PS_SB:
                    begin
                        if (b == tcoc_pkg::K_IAC)
                        begin
                            state_next = tcoc_pkg::PS_SBIAC;
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                    tcoc_pkg::PS_SBIAC:
                    begin
                        if (b == tcoc_pkg::K_IAC)
                        begin
                            push = 1'b1;
                            state_next = tcoc_pkg::PS_SB;
                        end
                        else
                        begin
                            job.kind = tcoc_pkg::JOB_REPLY;
                            state_next = tcoc_pkg::PS_DATA;
                            job.after_byte = b;
                            if (b != tcoc_pkg::K_SE)
                            begin
                                if (b == tcoc_pkg::K_IAC)
                                begin
                                    state_next = tcoc_pkg::PS_IAC;
                                end
                                else
                                begin
                                    job.bytes_after = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        state_next = tcoc_pkg::PS_DATA;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (push && cnt_reg < CW'(SB_DEPTH))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        job.telnet = telnet_next;
        job.owned = own_next;
    end

    assign job_valid = in_ok && (job.kind != tcoc_pkg::JOB_NONE || job.newcon);
    assign sb_we = in_ok && push && (cnt_reg < CW'(SB_DEPTH));
    assign sb_waddr = cnt_reg[$clog2(SB_DEPTH)-1:0];
    assign sb_wdata = push_byte;
    assign sb_count = cnt_reg;
    assign sb_hold = state_reg inside {tcoc_pkg::PS_IAC, tcoc_pkg::PS_SB, tcoc_pkg::PS_SBIAC};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcoc_pkg::PS_SNIFF;
            telnet_reg <= 1'b0;
            own_reg <= 1'b0;
            pend_reg <= '0;
            cnt_reg <= '0;
        end
        else if (in_ok)
        begin
            state_reg <= state_next;
            telnet_reg <= telnet_next;
            own_reg <= own_next;
            pend_reg <= pend_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/tcoc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcoc_queue: job queue
// A short register queue between the parser and the emitter.
// ----------------------------------------------------------------------------
module tcoc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcoc_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      n_reg;

    assign empty = (n_reg == '0);
    assign full = (n_reg == (AW+1)'(DEPTH));
    assign rdata = slot_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            n_reg <= n_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// File: hw/rtl/tcoc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcoc_back: result emitter
// Takes one job at a time, applies line coding changes and sends the
// resulting bytes one word a cycle while out_stall is low, through an output register.
// ----------------------------------------------------------------------------
module tcoc_back #(
    parameter int SB_DEPTH = tcoc_pkg::SB_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcoc_pkg::job_t                job,
    input  logic                          job_ready,
    output logic                          job_pop,
    input  tcoc_pkg::line_t               defaults,
    output logic [$clog2(SB_DEPTH)-1:0]   sb_raddr,
    input  logic [7:0]                    sb_rdata,
    input  logic [$clog2(SB_DEPTH+1)-1:0] sb_count,
    output tcoc_pkg::out_word_t           out_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          reply_done
);

    localparam int AW = $clog2(SB_DEPTH);
    localparam int CW = $clog2(SB_DEPTH + 1);

    tcoc_pkg::back_state_t st_reg, st_next;
    tcoc_pkg::line_t       line_reg, line_next;
    tcoc_pkg::job_t        cur_reg;
    logic [2:0]            ld_reg;
    logic [7:0]            sb0_reg, cmd_reg;
    logic [7:0]            v_reg [4];
    logic [3:0]            seq_len;
    logic [7:0]            seq [15];
    logic [3:0]            idx_reg;
    logic [7:0]            rb [4];
    logic [2:0]            rn;
    logic                  rvalid;
    logic [CW-1:0]         vlen;
    logic                  own;
    logic [7:0]            v0;
    logic [3:0]            k;
    logic [7:0]            resp;
    logic                  out_free;
    logic [31:0]           q;

    assign out_free = !out_valid || !out_stall;
    assign vlen = (sb_count >= CW'(2)) ? sb_count - CW'(2) : '0;
    assign own = cur_reg.owned;
    assign v0 = (vlen >= CW'(1)) ? v_reg[0] : 8'h00;
    assign sb_raddr = AW'(ld_reg);
    assign q = {v_reg[0], v_reg[1], v_reg[2], v_reg[3]};

    // Reply payload and line update for a completed subnegotiation.
    always_comb
    begin
        line_next = line_reg;
        rvalid = 1'b0;
        rn = 3'd1;
        resp = tcoc_pkg::K_RESP + cmd_reg;
        rb[0] = 8'h00;
        rb[1] = 8'h00;
        rb[2] = 8'h00;
        rb[3] = 8'h00;
        if (cur_reg.kind == tcoc_pkg::JOB_REPLY && sb_count >= CW'(2) &&
            sb0_reg == tcoc_pkg::K_CPO)
        begin
            rvalid = 1'b1;
            case (cmd_reg)
                8'd0: rn = 3'd0;
                8'd1:
                begin
                    if (vlen >= CW'(4) && q != 32'd0 && own)
                    begin
                        line_next.baud = q;
                    end
                    rn = 3'd4;
                    rb[0] = line_next.baud[31:24];
                    rb[1] = line_next.baud[23:16];
                    rb[2] = line_next.baud[15:8];
                    rb[3] = line_next.baud[7:0];
                end
                8'd2:
                begin
                    if (v0 != 8'd0 && own)
                    begin
                        line_next.data_bits = v0;
                    end
                    rb[0] = line_next.data_bits;
                end
                8'd3:
                begin
                    if (v0 != 8'd0 && own)
                    begin
                        line_next.parity = (v0 <= 8'd5) ? 3'(v0 - 8'd1) : 3'd0;
                    end
                    rb[0] = 8'(line_next.parity) + 8'd1;
                end
                8'd4:
                begin
                    if (v0 != 8'd0 && own)
                    begin
                        line_next.stop = (v0 == 8'd2) ? 2'd2 : ((v0 == 8'd3) ? 2'd1 : 2'd0);
                    end
                    rb[0] = (line_next.stop == 2'd2) ? 8'd2 :
                            ((line_next.stop == 2'd1) ? 8'd3 : 8'd1);
                end
                8'd5:
                begin
                    if (v0 <= 8'd3) rb[0] = 8'd1;
                    else if (v0 <= 8'd6) rb[0] = 8'd6;
                    else if (v0 <= 8'd9) rb[0] = 8'd8;
                    else if (v0 <= 8'd12) rb[0] = 8'd11;
                    else rb[0] = 8'd1;
                end
                8'd10, 8'd11: rb[0] = 8'd0;
                8'd12: rb[0] = v0;
                default: rvalid = 1'b0;
            endcase
        end
    end

    // Flatten the job into a byte sequence.
    always_comb
    begin
        for (int i = 0; i < 15; i++)
        begin
            seq[i] = 8'h00;
        end
        k = 4'd0;
        if (cur_reg.kind == tcoc_pkg::JOB_BYTES)
        begin
            seq[0] = cur_reg.b0;
            seq[1] = cur_reg.b1;
            seq[2] = cur_reg.b2;
            k = 4'(cur_reg.nbytes);
        end
        else if (cur_reg.kind == tcoc_pkg::JOB_REPLY)
        begin
            if (rvalid)
            begin
                seq[0] = tcoc_pkg::K_IAC;
                seq[1] = tcoc_pkg::K_SB;
                seq[2] = tcoc_pkg::K_CPO;
                seq[3] = resp;
                k = 4'd4;
                for (int j = 0; j < 4; j++)
                begin
                    if (3'(j) < rn)
                    begin
                        seq[k] = rb[j];
                        k = k + 4'd1;
                        if (rb[j] == tcoc_pkg::K_IAC)
                        begin
                            seq[k] = tcoc_pkg::K_IAC;
                            k = k + 4'd1;
                        end
                    end
                end
                seq[k] = tcoc_pkg::K_IAC;
                seq[k + 4'd1] = tcoc_pkg::K_SE;
                k = k + 4'd2;
            end
            if (cur_reg.bytes_after && k < 4'd15)
            begin
                seq[k] = cur_reg.after_byte;
                k = k + 4'd1;
            end
        end
        seq_len = k;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            tcoc_pkg::BS_IDLE:
            begin
                if (job_ready)
                begin
                    if (job.newcon)
                    begin
                        st_next = tcoc_pkg::BS_IDLE;
                    end
                    else if (job.kind == tcoc_pkg::JOB_REPLY)
                    begin
                        st_next = tcoc_pkg::BS_LOAD;
                    end
                    else
                    begin
                        st_next = tcoc_pkg::BS_EMIT;
                    end
                end
            end
            tcoc_pkg::BS_LOAD:
            begin
                if (ld_reg == 3'd6)
                begin
                    st_next = tcoc_pkg::BS_EMIT;
                end
            end
            tcoc_pkg::BS_EMIT:
            begin
                if (seq_len == 4'd0 || (out_free && idx_reg + 4'd1 >= seq_len))
                begin
                    st_next = tcoc_pkg::BS_IDLE;
                end
            end
            default: st_next = tcoc_pkg::BS_IDLE;
        endcase
    end

    always_comb
    begin
        job_pop = (st_reg == tcoc_pkg::BS_IDLE) && job_ready;
    end

    assign reply_done = (st_reg == tcoc_pkg::BS_EMIT) && (st_next == tcoc_pkg::BS_IDLE) &&
                        (cur_reg.kind == tcoc_pkg::JOB_REPLY);

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            cur_reg <= job;
        end
        if (st_reg == tcoc_pkg::BS_LOAD)
        begin
            case (ld_reg)
                3'd1: sb0_reg <= sb_rdata;
                3'd2: cmd_reg <= sb_rdata;
                3'd3: v_reg[0] <= sb_rdata;
                3'd4: v_reg[1] <= sb_rdata;
                3'd5: v_reg[2] <= sb_rdata;
                3'd6: v_reg[3] <= sb_rdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= tcoc_pkg::BS_IDLE;
            ld_reg <= '0;
            idx_reg <= '0;
            line_reg <= '{baud: 32'd115200, data_bits: 8'd8, parity: 3'd0, stop: 2'd0};
            out_valid <= 1'b0;
            out_word <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            if (job_pop && job.newcon)
            begin
                line_reg <= defaults;
            end
            if (job_pop)
            begin
                ld_reg <= '0;
                idx_reg <= '0;
            end
            else if (st_reg == tcoc_pkg::BS_LOAD)
            begin
                ld_reg <= ld_reg + 3'd1;
            end
            if (st_reg == tcoc_pkg::BS_EMIT && out_free && seq_len != 4'd0)
            begin
                out_valid <= 1'b1;
                out_word.dest <= cur_reg.dest || (cur_reg.kind == tcoc_pkg::JOB_REPLY &&
                                 !(cur_reg.bytes_after && idx_reg + 4'd1 == seq_len));
                out_word.byte_out <= seq[idx_reg];
                out_word.last <= (idx_reg + 4'd1 >= seq_len);
                out_word.line_baud <= line_next.baud;
                out_word.line_data_bits <= line_next.data_bits;
                out_word.line_parity <= line_next.parity;
                out_word.line_stop <= line_next.stop;
                out_word.telnet_active <= cur_reg.telnet;
                out_word.owns_line <= cur_reg.owned;
                idx_reg <= idx_reg + 4'd1;
            end
            if (reply_done)
            begin
                line_reg <= line_next;
            end
        end
    end

endmodule

// File: hw/rtl/telnet_comport_option_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_comport_option_codec: telnet and com-port option codec
// Channel  Direction  Word                   Handshake
// in       input      tcoc_pkg::in_word_t    in_valid / in_stall
// out      output     tcoc_pkg::out_word_t   out_valid / out_stall
// cfg      input      index + 32-bit data    cfg_we
// The parser takes one word a cycle while the four-job queue has room. A job
// holds the emitter until its result words have gone out, a new connection
// is taken in the idle state; a subnegotiation reply first reads the store.
// Until a reply has gone out, input stalls once the parser reaches an IAC.
// Reset restores the default line coding and the sniffing state.
// ----------------------------------------------------------------------------
module telnet_comport_option_codec #(
    parameter int SB_DEPTH = tcoc_pkg::SB_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tcoc_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output tcoc_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    localparam int AW = $clog2(SB_DEPTH);
    localparam int CW = $clog2(SB_DEPTH + 1);
    localparam int JW = $bits(tcoc_pkg::job_t);

    tcoc_pkg::line_t defaults_reg;
    logic            ctrl_reg;
    logic            in_ok;
    tcoc_pkg::job_t  fjob, bjob;
    logic            fjob_valid;
    logic            q_empty, q_full, q_pop;
    logic            sb_we;
    logic [AW-1:0]   sb_waddr, sb_raddr;
    logic [7:0]      sb_wdata, sb_rdata;
    logic [CW-1:0]   sb_count;
    logic [JW-1:0]   q_rdata;
    logic            sb_hold;
    logic            reply_done;
    logic            reply_busy_reg;

    assign in_stall = q_full || (reply_busy_reg && sb_hold);
    assign in_ok = in_valid && !in_stall;
    assign bjob = tcoc_pkg::job_t'(q_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_busy_reg <= 1'b0;
        end
        else if (fjob_valid && fjob.kind == tcoc_pkg::JOB_REPLY)
        begin
            reply_busy_reg <= 1'b1;
        end
        else if (reply_done)
        begin
            reply_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            defaults_reg <= '{baud: 32'd115200, data_bits: 8'd8, parity: 3'd0, stop: 2'd0};
            ctrl_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcoc_pkg::CFG_BAUD:   defaults_reg.baud <= cfg_data;
                tcoc_pkg::CFG_DBITS:  defaults_reg.data_bits <= cfg_data[7:0];
                tcoc_pkg::CFG_PARITY: defaults_reg.parity <= cfg_data[2:0];
                tcoc_pkg::CFG_STOP:   defaults_reg.stop <= cfg_data[1:0];
                tcoc_pkg::CFG_CTRL:   ctrl_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    tcoc_front #(.SB_DEPTH(SB_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_ok(in_ok), .in_word(in_word),
        .control_allowed(ctrl_reg), .job(fjob), .job_valid(fjob_valid),
        .sb_we(sb_we), .sb_waddr(sb_waddr), .sb_wdata(sb_wdata), .sb_count(sb_count),
        .sb_hold(sb_hold)
    );

    tcoc_ram #(.WIDTH(8), .DEPTH(SB_DEPTH)) u_sb (
        .clk(clk), .we(sb_we), .waddr(sb_waddr), .wdata(sb_wdata),
        .raddr(sb_raddr), .rdata(sb_rdata)
    );

    tcoc_queue #(.WIDTH(JW), .DEPTH(tcoc_pkg::QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(fjob_valid), .wdata(JW'(fjob)),
        .pop(q_pop), .rdata(q_rdata), .empty(q_empty), .full(q_full)
    );

    tcoc_back #(.SB_DEPTH(SB_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .job(bjob), .job_ready(!q_empty), .job_pop(q_pop),
        .defaults(defaults_reg), .sb_raddr(sb_raddr), .sb_rdata(sb_rdata),
        .sb_count(sb_count), .out_word(out_word), .out_valid(out_valid),
        .out_stall(out_stall), .reply_done(reply_done)
    );

endmodule
